>>> sv/mexp_pkg.sv
// shared constants and types for the modular exponentiation block
`default_nettype none
package mexp_pkg;

    localparam int OPERAND_WIDTH = 32;
    localparam int CNT_W         = $clog2(OPERAND_WIDTH);

    // modx is the modulus with one extra bit: zero modulus becomes 2^OPERAND_WIDTH
    typedef struct packed {
        logic [OPERAND_WIDTH:0]   modx;
        logic [OPERAND_WIDTH-1:0] a;
        logic [OPERAND_WIDTH-1:0] b;
    } t_mul_req;

endpackage
`default_nettype wire

>>> sv/mexp_mulmod.sv
// bit-serial interleaved modular multiplier, one multiplier bit per cycle
`default_nettype none
module mexp_mulmod (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire mexp_pkg::t_mul_req                  i_req,
    output logic                                     o_done,
    output logic [mexp_pkg::OPERAND_WIDTH-1:0]       o_result
);

    localparam int W = mexp_pkg::OPERAND_WIDTH;

    logic [W-1:0]               r_acc, n_acc;
    logic [W-1:0]               r_a;
    logic [W-1:0]               r_b;
    logic [W:0]                 r_modx;
    logic [mexp_pkg::CNT_W-1:0] r_cnt;
    logic                       r_busy;
    logic                       r_done;

    logic [W+1:0] sum;
    logic [W+1:0] mod1;
    logic [W+1:0] mod2;

    // 2*acc + bit*a stays below three times the modulus
    always_comb begin
        sum  = {1'b0, r_acc, 1'b0} + (r_b[W-1] ? {2'b00, r_a} : {(W+2){1'b0}});
        mod1 = {1'b0, r_modx};
        mod2 = {r_modx, 1'b0};
        if (sum >= mod2) begin
            n_acc = W'(sum - mod2);
        end else if (sum >= mod1) begin
            n_acc = W'(sum - mod1);
        end else begin
            n_acc = W'(sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= mexp_pkg::CNT_W'(W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc  <= '0;
            r_a    <= i_req.a;
            r_b    <= i_req.b;
            r_modx <= i_req.modx;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[W-2:0], 1'b0};
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule
`default_nettype wire

>>> sv/modular_exponentiation.sv
// modular exponentiation top level: square-and-multiply sequencer over a serial multiplier
// a zero exponent goes straight to output; otherwise the base is first reduced by one multiply,
// then one multiply per set exponent bit plus one squaring per bit below the top set bit
// a multiply steps through every operand bit, then a step state follows; a full output adds stalls
// throughput: one word at a time; the next word is taken once the result sits in the output register
// reset: synchronous active-low, clears the sequencer and the output valid
`default_nettype none
module modular_exponentiation (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    input  wire logic [3*mexp_pkg::OPERAND_WIDTH-1:0]   i_s_axis_tdata,  // base_value, exponent, modulus
    output logic                                        o_m_axis_tvalid,
    input  wire logic                                   i_m_axis_tready,
    output logic [mexp_pkg::OPERAND_WIDTH-1:0]          o_m_axis_tdata   // power_mod
);

    localparam int W = mexp_pkg::OPERAND_WIDTH;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_STEP = 3'd2;
    localparam logic [2:0] S_MACC = 3'd3;
    localparam logic [2:0] S_MSQ  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]         r_state;
    logic [W-1:0]       r_e;
    logic [W-1:0]       r_sq;
    logic [W-1:0]       r_acc;
    logic [W:0]         r_modx;
    logic [W-1:0]       r_res;
    logic [W-1:0]       r_out;
    logic               r_out_valid;
    logic               r_start;
    mexp_pkg::t_mul_req r_req;

    logic         mul_done;
    logic [W-1:0] mul_res;

    logic         in_acc;
    logic [W-1:0] in_base;
    logic [W-1:0] in_exp;
    logic [W-1:0] in_mod;
    logic [W-1:0] one_mod;

    assign in_base = i_s_axis_tdata[W-1:0];
    assign in_exp  = i_s_axis_tdata[2*W-1:W];
    assign in_mod  = i_s_axis_tdata[3*W-1:2*W];
    assign in_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign one_mod = (in_mod == W'(1)) ? '0 : W'(1);

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    mexp_mulmod u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_start),
        .i_req    (r_req),
        .o_done   (mul_done),
        .o_result (mul_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= (r_state == S_IDLE && in_acc && in_exp != '0)
                    || (r_state == S_STEP && (r_e[0] || r_e[W-1:1] != '0));
            if (r_state == S_OUT && (!r_out_valid || i_m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (in_exp == '0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    if (mul_done) begin
                        r_state <= S_STEP;
                    end
                end
                S_STEP: begin
                    if (r_e[0]) begin
                        r_state <= S_MACC;
                    end else if (r_e[W-1:1] == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MSQ;
                    end
                end
                S_MACC: begin
                    if (mul_done) begin
                        r_state <= S_STEP;
                    end
                end
                S_MSQ: begin
                    if (mul_done) begin
                        r_state <= S_STEP;
                    end
                end
                S_OUT: begin
                    if (!r_out_valid || i_m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_e    <= in_exp;
                    r_modx <= {(in_mod == '0), in_mod};
                    r_acc  <= one_mod;
                    r_res  <= W'(1);
                    // base reduced as (1 mod m) * base
                    r_req.modx <= {(in_mod == '0), in_mod};
                    r_req.a    <= one_mod;
                    r_req.b    <= in_base;
                end
            end
            S_RED: begin
                if (mul_done) begin
                    r_sq <= mul_res;
                end
            end
            S_STEP: begin
                r_req.modx <= r_modx;
                if (r_e[0]) begin
                    r_e     <= {r_e[W-1:1], 1'b0};
                    r_req.a <= r_acc;
                    r_req.b <= r_sq;
                end else if (r_e[W-1:1] == '0) begin
                    r_res <= r_acc;
                end else begin
                    r_e     <= {1'b0, r_e[W-1:1]};
                    r_req.a <= r_sq;
                    r_req.b <= r_sq;
                end
            end
            S_MACC: begin
                if (mul_done) begin
                    r_acc <= mul_res;
                end
            end
            S_MSQ: begin
                if (mul_done) begin
                    r_sq <= mul_res;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    r_out <= r_res;
                end
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_done_in_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_RED || r_state == S_MACC || r_state == S_MSQ))
        else $error("multiplier finished outside a multiply state");

    a_zero_exp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_exp == '0) |=> (r_state == S_OUT && r_res == W'(1)))
        else $error("zero exponent did not go straight to output");

    a_start_on_go: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && in_exp != '0) |=> (r_start && r_state == S_RED))
        else $error("nonzero exponent did not start base reduction");

    a_out_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_out_valid && !i_m_axis_tready) |=> (r_state == S_OUT))
        else $error("result left while output register was full");
`endif

endmodule
`default_nettype wire
